/* hdl/pcsc_pkg.sv */
// Package: shared types, conversion codes and coefficient helpers for the colour converter
`timescale 1ns / 1ps
package pcsc_pkg;

  localparam int COEF_FRAC_BITS_DEF = 12;
  localparam int SAMP_W             = 18;
  localparam longint MICRO          = 1000000;
  localparam longint HALF_MICRO     = 500000;

  localparam logic [6:0] CC_BGR2BGRA  = 7'd0;
  localparam logic [6:0] CC_BGRA2BGR  = 7'd1;
  localparam logic [6:0] CC_BGR2RGBA  = 7'd2;
  localparam logic [6:0] CC_RGBA2BGR  = 7'd3;
  localparam logic [6:0] CC_BGR2RGB   = 7'd4;
  localparam logic [6:0] CC_BGRA2RGBA = 7'd5;
  localparam logic [6:0] CC_BGR2GRAY  = 7'd6;
  localparam logic [6:0] CC_RGB2GRAY  = 7'd7;
  localparam logic [6:0] CC_GRAY2BGR  = 7'd8;
  localparam logic [6:0] CC_GRAY2BGRA = 7'd9;
  localparam logic [6:0] CC_BGRA2GRAY = 7'd10;
  localparam logic [6:0] CC_RGBA2GRAY = 7'd11;
  localparam logic [6:0] CC_BGR2XYZ   = 7'd32;
  localparam logic [6:0] CC_RGB2XYZ   = 7'd33;
  localparam logic [6:0] CC_XYZ2BGR   = 7'd34;
  localparam logic [6:0] CC_XYZ2RGB   = 7'd35;
  localparam logic [6:0] CC_BGR2YCRCB = 7'd36;
  localparam logic [6:0] CC_RGB2YCRCB = 7'd37;
  localparam logic [6:0] CC_YCRCB2BGR = 7'd38;
  localparam logic [6:0] CC_YCRCB2RGB = 7'd39;
  localparam logic [6:0] CC_BGR2YUV   = 7'd82;
  localparam logic [6:0] CC_RGB2YUV   = 7'd83;
  localparam logic [6:0] CC_YUV2BGR   = 7'd84;
  localparam logic [6:0] CC_YUV2RGB   = 7'd85;

  localparam logic [1:0] REG_CODE  = 2'd0;
  localparam logic [1:0] REG_S16   = 2'd1;
  localparam logic [1:0] REG_IALPH = 2'd2;
  localparam logic [1:0] REG_OALPH = 2'd3;

  typedef struct packed {
    logic [15:0] in_c0;
    logic [15:0] in_c1;
    logic [15:0] in_c2;
    logic [15:0] in_c3;
  } pcsc_in_t;

  typedef struct packed {
    logic [15:0] out_c0;
    logic [15:0] out_c1;
    logic [15:0] out_c2;
    logic [15:0] out_c3;
    logic [2:0]  out_channels;
    logic        bad_code;
  } pcsc_out_t;

  typedef struct packed {
    logic [6:0] code;
    logic       s16;
    logic       in_alpha;
    logic       out_alpha;
  } pcsc_cfg_t;

  typedef struct packed {
    logic [2:0]  row_en;
    logic [2:0]  chroma;
    logic [2:0]  nch;
    logic        bad;
    logic        alpha_en;
    logic [15:0] alpha;
    logic        s16;
  } pcsc_ctl_t;

  // round to nearest, ties away from zero
  function automatic longint fxc(input longint micro, input int f);
    longint scale;
    scale = longint'(1) << f;
    if (micro >= 0) return (micro * scale + HALF_MICRO) / MICRO;
    return -((-micro * scale + HALF_MICRO) / MICRO);
  endfunction

endpackage

/* hdl/pcsc_decode.sv */
// Mode decode: sample masking, offset removal and coefficient selection (one stage)
`timescale 1ns / 1ps
module pcsc_decode import pcsc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int CW = COEF_FRAC_BITS + 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pcsc_cfg_t                cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  pcsc_in_t                 in_data,
  output logic                     dec_valid,
  input  logic                     dec_stall,
  output logic [2:0][SAMP_W-1:0]   dec_samp,
  output logic [8:0][CW-1:0]       dec_coef,
  output logic [2:0][CW-1:0]       dec_k,
  output pcsc_ctl_t                dec_ctl
);

  localparam int F = COEF_FRAC_BITS;
  localparam logic [CW-1:0] ONE  = CW'(longint'(1) << F);
  localparam logic [CW-1:0] KYB  = CW'(fxc(114000, F));
  localparam logic [CW-1:0] KYG  = CW'(fxc(587000, F));
  localparam logic [CW-1:0] KYR  = CW'(fxc(299000, F));
  localparam logic [CW-1:0] KCR  = CW'(fxc(713000, F));
  localparam logic [CW-1:0] KCB  = CW'(fxc(564000, F));
  localparam logic [CW-1:0] KV   = CW'(fxc(877000, F));
  localparam logic [CW-1:0] KU   = CW'(fxc(492000, F));
  localparam logic [CW-1:0] IC0  = CW'(fxc(1403000, F));
  localparam logic [CW-1:0] IC1  = CW'(fxc(-714000, F));
  localparam logic [CW-1:0] IC2  = CW'(fxc(-344000, F));
  localparam logic [CW-1:0] IC3  = CW'(fxc(1773000, F));
  localparam logic [CW-1:0] IU0  = CW'(fxc(1140000, F));
  localparam logic [CW-1:0] IU1  = CW'(fxc(-581000, F));
  localparam logic [CW-1:0] IU2  = CW'(fxc(-395000, F));
  localparam logic [CW-1:0] IU3  = CW'(fxc(2032000, F));
  localparam logic [8:0][CW-1:0] FXYZ = {
    CW'(fxc(950227, F)), CW'(fxc(119193, F)), CW'(fxc(19334, F)),
    CW'(fxc(72169, F)),  CW'(fxc(715160, F)), CW'(fxc(212671, F)),
    CW'(fxc(180423, F)), CW'(fxc(357580, F)), CW'(fxc(412453, F))};
  localparam logic [8:0][CW-1:0] IXYZ = {
    CW'(fxc(1057311, F)), CW'(fxc(-204043, F)), CW'(fxc(55648, F)),
    CW'(fxc(41556, F)),   CW'(fxc(1875991, F)), CW'(fxc(-969256, F)),
    CW'(fxc(-498535, F)), CW'(fxc(-1537150, F)), CW'(fxc(3240479, F))};

  logic                   en;
  logic                   v_r;
  logic [2:0][SAMP_W-1:0] samp_r, samp_nxt;
  logic [8:0][CW-1:0]     coef_r, coef_nxt;
  logic [2:0][CW-1:0]     k_r, k_nxt;
  pcsc_ctl_t              ctl_r, ctl_nxt;
  logic [15:0]            maxv, s0, s1, s2, s3;
  logic [SAMP_W-1:0]      delta;
  logic                   swp, rgb, yuv;
  logic [1:0]             ri, bi, r0, r2;

  assign en = !v_r || !dec_stall;
  assign in_stall = !en;

  always_comb begin
    maxv  = cfg.s16 ? 16'hFFFF : 16'h00FF;
    delta = cfg.s16 ? SAMP_W'(32768) : SAMP_W'(128);
    s0 = in_data.in_c0 & maxv;
    s1 = in_data.in_c1 & maxv;
    s2 = in_data.in_c2 & maxv;
    s3 = in_data.in_c3 & maxv;
    swp = cfg.code >= CC_BGR2RGBA;
    rgb = (cfg.code == CC_RGB2GRAY) || (cfg.code == CC_RGBA2GRAY) ||
          (cfg.code == CC_RGB2XYZ) || (cfg.code == CC_XYZ2RGB) ||
          (cfg.code == CC_RGB2YCRCB) || (cfg.code == CC_YCRCB2RGB) ||
          (cfg.code == CC_RGB2YUV) || (cfg.code == CC_YUV2RGB);
    yuv = cfg.code >= CC_BGR2YUV;
    ri  = rgb ? 2'd0 : 2'd2;
    bi  = rgb ? 2'd2 : 2'd0;
    r0  = rgb ? 2'd0 : 2'd2;
    r2  = rgb ? 2'd2 : 2'd0;
    samp_nxt = {SAMP_W'(s2), SAMP_W'(s1), SAMP_W'(s0)};
    coef_nxt = '0;
    k_nxt    = {ONE, ONE, ONE};
    ctl_nxt  = '{row_en: 3'b111, chroma: 3'b000, nch: 3'd3, bad: 1'b0,
                 alpha_en: 1'b0, alpha: maxv, s16: cfg.s16};
    unique case (cfg.code)
      CC_BGR2BGRA, CC_BGRA2BGR, CC_BGR2RGBA, CC_RGBA2BGR, CC_BGR2RGB,
      CC_BGRA2RGBA: begin
        coef_nxt[swp ? 2 : 0] = ONE;
        coef_nxt[4]           = ONE;
        coef_nxt[swp ? 6 : 8] = ONE;
        if (cfg.code == CC_BGR2BGRA || cfg.code == CC_BGR2RGBA ||
            cfg.code == CC_BGRA2RGBA) begin
          ctl_nxt.alpha_en = 1'b1;
          ctl_nxt.nch      = 3'd4;
          if (cfg.in_alpha) ctl_nxt.alpha = s3;
        end
      end
      CC_BGR2GRAY, CC_RGB2GRAY, CC_BGRA2GRAY, CC_RGBA2GRAY: begin
        coef_nxt[bi] = KYB;
        coef_nxt[1]  = KYG;
        coef_nxt[ri] = KYR;
        ctl_nxt.row_en = 3'b001;
        ctl_nxt.nch    = 3'd1;
      end
      CC_GRAY2BGR, CC_GRAY2BGRA: begin
        coef_nxt[0] = ONE;
        coef_nxt[3] = ONE;
        coef_nxt[6] = ONE;
        if (cfg.code == CC_GRAY2BGRA) begin
          ctl_nxt.alpha_en = 1'b1;
          ctl_nxt.nch      = 3'd4;
        end
      end
      CC_BGR2XYZ, CC_RGB2XYZ: begin
        for (int j = 0; j < 3; j++) begin
          coef_nxt[3*j + ri] = FXYZ[3*j];
          coef_nxt[3*j + 1]  = FXYZ[3*j + 1];
          coef_nxt[3*j + bi] = FXYZ[3*j + 2];
        end
      end
      CC_XYZ2BGR, CC_XYZ2RGB: begin
        for (int i = 0; i < 3; i++) begin
          coef_nxt[i]     = IXYZ[3*r0 + i];
          coef_nxt[3 + i] = IXYZ[3 + i];
          coef_nxt[6 + i] = IXYZ[3*r2 + i];
        end
        ctl_nxt.alpha_en = cfg.out_alpha;
        ctl_nxt.nch      = cfg.out_alpha ? 3'd4 : 3'd3;
      end
      CC_BGR2YCRCB, CC_RGB2YCRCB, CC_BGR2YUV, CC_RGB2YUV: begin
        coef_nxt[bi] = KYB;
        coef_nxt[1]  = KYG;
        coef_nxt[ri] = KYR;
        // chroma rows: (sample * one - luma) then scaled
        coef_nxt[yuv ? 3 + bi : 3 + ri] = yuv ? ONE - KYB : ONE - KYR;
        coef_nxt[yuv ? 3 + ri : 3 + bi] = yuv ? -KYR : -KYB;
        coef_nxt[4] = -KYG;
        coef_nxt[yuv ? 6 + ri : 6 + bi] = yuv ? ONE - KYR : ONE - KYB;
        coef_nxt[yuv ? 6 + bi : 6 + ri] = yuv ? -KYB : -KYR;
        coef_nxt[7] = -KYG;
        k_nxt[1] = yuv ? KU : KCR;
        k_nxt[2] = yuv ? KV : KCB;
        ctl_nxt.chroma = 3'b110;
      end
      CC_YCRCB2BGR, CC_YCRCB2RGB, CC_YUV2BGR, CC_YUV2RGB: begin
        samp_nxt[1] = SAMP_W'(yuv ? s2 : s1) - delta;
        samp_nxt[2] = SAMP_W'(yuv ? s1 : s2) - delta;
        coef_nxt[0] = ONE;
        coef_nxt[3] = ONE;
        coef_nxt[6] = ONE;
        coef_nxt[rgb ? 1 : 7] = yuv ? IU0 : IC0;
        coef_nxt[4]           = yuv ? IU1 : IC1;
        coef_nxt[5]           = yuv ? IU2 : IC2;
        coef_nxt[rgb ? 8 : 2] = yuv ? IU3 : IC3;
        ctl_nxt.alpha_en = cfg.out_alpha;
        ctl_nxt.nch      = cfg.out_alpha ? 3'd4 : 3'd3;
      end
      default: begin
        ctl_nxt.row_en = 3'b000;
        ctl_nxt.nch    = 3'd0;
        ctl_nxt.bad    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      samp_r <= samp_nxt;
      coef_r <= coef_nxt;
      k_r    <= k_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  assign dec_valid = v_r;
  assign dec_samp  = samp_r;
  assign dec_coef  = coef_r;
  assign dec_k     = k_r;
  assign dec_ctl   = ctl_r;

endmodule

/* hdl/pcsc_mac.sv */
// Matrix stages: nine products, then three row sums
`timescale 1ns / 1ps
module pcsc_mac import pcsc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int CW = COEF_FRAC_BITS + 4,
  localparam int AW = COEF_FRAC_BITS + 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0][SAMP_W-1:0] in_samp,
  input  logic [8:0][CW-1:0]     in_coef,
  input  logic [2:0][CW-1:0]     in_k,
  input  pcsc_ctl_t              in_ctl,
  output logic                   acc_valid,
  input  logic                   acc_stall,
  output logic [2:0][AW-1:0]     acc_sum,
  output logic [2:0][CW-1:0]     acc_k,
  output pcsc_ctl_t              acc_ctl
);

  localparam int PW = CW + SAMP_W;
  localparam int SW = PW + 2;

  logic               en2, en3, v2_r, v3_r;
  logic [8:0][PW-1:0] prod_r;
  logic [2:0][CW-1:0] k2_r, k3_r;
  pcsc_ctl_t          ctl2_r, ctl3_r;
  logic [2:0][AW-1:0] sum_r, sum_nxt;

  assign en3 = !v3_r || !acc_stall;
  assign en2 = !v2_r || en3;
  assign in_stall = !en2;

  for (genvar g = 0; g < 9; g++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en2) begin
        prod_r[g] <= PW'($signed(in_coef[g]) * $signed(in_samp[g % 3]));
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum_nxt[j] = AW'($signed(SW'($signed(prod_r[3*j]))) +
                       $signed(SW'($signed(prod_r[3*j + 1]))) +
                       $signed(SW'($signed(prod_r[3*j + 2]))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en2) v2_r <= in_valid;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      k2_r   <= in_k;
      ctl2_r <= in_ctl;
    end
    if (en3) begin
      sum_r  <= sum_nxt;
      k3_r   <= k2_r;
      ctl3_r <= ctl2_r;
    end
  end

  assign acc_valid = v3_r;
  assign acc_sum   = sum_r;
  assign acc_k     = k3_r;
  assign acc_ctl   = ctl3_r;

endmodule

/* hdl/pcsc_scale.sv */
// Output stages: row scaling, chroma offset, clamp and result assembly
`timescale 1ns / 1ps
module pcsc_scale import pcsc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int CW = COEF_FRAC_BITS + 4,
  localparam int AW = COEF_FRAC_BITS + 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0][AW-1:0] in_sum,
  input  logic [2:0][CW-1:0] in_k,
  input  pcsc_ctl_t          in_ctl,
  output logic               out_valid,
  input  logic               out_stall,
  output pcsc_out_t          out_data
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int MW = AW + CW;
  localparam int BW = MW + 1;
  localparam int VW = BW - 2 * F;

  logic               en4, en5, v4_r, v5_r;
  logic [2:0][MW-1:0] m_r;
  pcsc_ctl_t          ctl4_r;
  logic [2:0][15:0]   ch;
  logic [BW-1:0]      b;
  logic [VW-1:0]      v;
  logic [15:0]        maxv;
  pcsc_out_t          res_r, res_nxt;

  assign en5 = !v5_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign in_stall = !en4;

  always_comb begin
    maxv = ctl4_r.s16 ? 16'hFFFF : 16'h00FF;
    for (int j = 0; j < 3; j++) begin
      b = BW'($signed(m_r[j])) +
          (ctl4_r.chroma[j] ? (BW'(ctl4_r.s16 ? 32768 : 128) << (2 * F)) : BW'(0));
      v = b[BW-1:2*F];
      if (b[BW-1] || b == '0 || !ctl4_r.row_en[j]) ch[j] = '0;
      else if (v > VW'(maxv)) ch[j] = ctl4_r.row_en[j] ? maxv : 16'd0;
      else ch[j] = v[15:0];
    end
    res_nxt.out_c0       = ch[0];
    res_nxt.out_c1       = ch[1];
    res_nxt.out_c2       = ch[2];
    res_nxt.out_c3       = ctl4_r.alpha_en ? ctl4_r.alpha : 16'd0;
    res_nxt.out_channels = ctl4_r.nch;
    res_nxt.bad_code     = ctl4_r.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int j = 0; j < 3; j++) m_r[j] <= MW'($signed(in_sum[j]) * $signed(in_k[j]));
      ctl4_r <= in_ctl;
    end
    if (en5) res_r <= res_nxt;
  end

  assign out_valid = v5_r;
  assign out_data  = res_r;

endmodule

/* hdl/pixel_color_space_converter_unit.sv */
// Throughput: one pixel per cycle; each stage advances whenever its successor frees up.
// Stages: decode, products, row sums, row scaling, clamp/output register.
// Reset (synchronous, active low) clears the stage valid bits and the four
// configuration registers to zero.
`timescale 1ns / 1ps
module pixel_color_space_converter_unit import pcsc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pcsc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pcsc_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int CW = COEF_FRAC_BITS + 4;
  localparam int AW = COEF_FRAC_BITS + 20;

  pcsc_cfg_t              cfg_r;
  logic                   dec_valid, dec_stall, acc_valid, acc_stall;
  logic [2:0][SAMP_W-1:0] dec_samp;
  logic [8:0][CW-1:0]     dec_coef;
  logic [2:0][CW-1:0]     dec_k, acc_k;
  pcsc_ctl_t              dec_ctl, acc_ctl;
  logic [2:0][AW-1:0]     acc_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CODE:  cfg_r.code      <= cfg_data;
        REG_S16:   cfg_r.s16       <= cfg_data[0];
        REG_IALPH: cfg_r.in_alpha  <= cfg_data[0];
        REG_OALPH: cfg_r.out_alpha <= cfg_data[0];
        default:   cfg_r           <= cfg_r;
      endcase
    end
  end

  pcsc_decode #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_decode (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid, .in_stall, .in_data,
    .dec_valid, .dec_stall, .dec_samp, .dec_coef, .dec_k, .dec_ctl
  );

  pcsc_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk, .rst_n,
    .in_valid(dec_valid), .in_stall(dec_stall), .in_samp(dec_samp),
    .in_coef(dec_coef), .in_k(dec_k), .in_ctl(dec_ctl),
    .acc_valid, .acc_stall, .acc_sum, .acc_k, .acc_ctl
  );

  pcsc_scale #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_scale (
    .clk, .rst_n,
    .in_valid(acc_valid), .in_stall(acc_stall), .in_sum(acc_sum),
    .in_k(acc_k), .in_ctl(acc_ctl),
    .out_valid, .out_stall, .out_data
  );

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_code |->
      out_data.out_channels == 3'd0 && out_data.out_c0 == 16'd0 &&
      out_data.out_c3 == 16'd0)
    else $error("unsupported code result not cleared");

  a_nch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_channels <= 3'd4)
    else $error("channel count out of range");

  a_gray_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_channels == 3'd1 |->
      out_data.out_c1 == 16'd0 && out_data.out_c2 == 16'd0 && out_data.out_c3 == 16'd0)
    else $error("unused channels not zero");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

endmodule
